### src/pitsr_pkg.sv
// ----------------------------------------------------------------------------
// pitsr_pkg: shared types and constants of the packed id table
// Sizes of the id space, the dense table and the signatures, the operation
// and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package pitsr_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int ID_BITS     = 10;
	localparam int SIG_BITS    = 32;
	localparam int ID_SPACE    = 1 << ID_BITS;
	localparam int SLOT_BITS   = $clog2(MAX_ENTRIES);
	localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
	localparam int MAP_BITS    = SLOT_BITS + 1;

	typedef enum logic [2:0] {
		KIND_ADD    = 3'd0,
		KIND_FIND   = 3'd1,
		KIND_REMOVE = 3'd2,
		KIND_READ   = 3'd3,
		KIND_WRITE  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_PRESENT   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_READ,
		ST_REMOVE,
		ST_REMOVE2
	} state_t;

endpackage

### src/pitsr_ram.sv
// ----------------------------------------------------------------------------
// pitsr_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module pitsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/packed_id_table_swap_remove_top.sv
// ----------------------------------------------------------------------------
// packed_id_table_swap_remove_top: dense table of live ids with id-to-slot map
// Add, find, swap-remove, read and write of per-entity signatures, one
// operation per transaction, state held in three synchronous RAMs.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   in      | in_valid / in_stall | kind, entity_id, new_signature
//   out     | out_valid/out_stall | status, slot, signature_out, live_count
//
// Add, find, write, refused and unused kinds finish in ST_LOOKUP, a signature
// read goes on through ST_READ and a remove through ST_REMOVE and ST_REMOVE2,
// the sequencer walking one RAM access at a time through the map, slot and
// signature memories. After reset a clearing pass invalidates every entry of
// the id map; in_stall stays high during it. A result waiting on out_stall
// holds the sequencer in its final state; one new transaction can be accepted
// while an earlier result still waits in the output register.
// ----------------------------------------------------------------------------
module packed_id_table_swap_remove_top
	import pitsr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          kind,
	input  logic [ID_BITS-1:0]  entity_id,
	input  logic [SIG_BITS-1:0] new_signature,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [SLOT_BITS-1:0] slot,
	output logic [SIG_BITS-1:0] signature_out,
	output logic [CNT_BITS-1:0] live_count
);

	state_t state_q, state_d;
	logic [ID_BITS-1:0]   clr_q;
	logic [2:0]           kind_q;
	logic [ID_BITS-1:0]   id_q;
	logic [SIG_BITS-1:0]  sig_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [SLOT_BITS-1:0] slot_d;
	logic [CNT_BITS-1:0]  count_q, count_d;

	logic                 out_valid_q;
	status_t              status_q;
	logic [SLOT_BITS-1:0] slot_out_q;
	logic [SIG_BITS-1:0]  sig_out_q;
	logic [CNT_BITS-1:0]  count_out_q;

	logic                 emit;
	status_t              em_status;
	logic [SLOT_BITS-1:0] em_slot;
	logic [SIG_BITS-1:0]  em_sig;

	logic                 accept;
	logic                 out_free;
	logic                 present;
	logic [SLOT_BITS-1:0] map_slot;
	logic [SLOT_BITS-1:0] last_slot;
	logic                 full;

	logic                 map_we, map_re;
	logic [ID_BITS-1:0]   map_waddr, map_raddr;
	logic [MAP_BITS-1:0]  map_wdata, map_rdata;
	logic                 sid_we, sid_re;
	logic [SLOT_BITS-1:0] sid_waddr, sid_raddr;
	logic [ID_BITS-1:0]   sid_wdata, sid_rdata;
	logic                 sig_we, sig_re;
	logic [SLOT_BITS-1:0] sig_waddr, sig_raddr;
	logic [SIG_BITS-1:0]  sig_wdata, sig_rdata;

	pitsr_ram #(.WIDTH(MAP_BITS), .DEPTH(ID_SPACE)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	pitsr_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_ENTRIES)) u_sid_ram (
		.clk   (clk),
		.we    (sid_we),
		.waddr (sid_waddr),
		.wdata (sid_wdata),
		.re    (sid_re),
		.raddr (sid_raddr),
		.rdata (sid_rdata)
	);

	pitsr_ram #(.WIDTH(SIG_BITS), .DEPTH(MAX_ENTRIES)) u_sig_ram (
		.clk   (clk),
		.we    (sig_we),
		.waddr (sig_waddr),
		.wdata (sig_wdata),
		.re    (sig_re),
		.raddr (sig_raddr),
		.rdata (sig_rdata)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign present   = map_rdata[SLOT_BITS];
	assign map_slot  = map_rdata[SLOT_BITS-1:0];
	assign full      = (count_q == CNT_BITS'(MAX_ENTRIES));
	assign last_slot = SLOT_BITS'(count_q - CNT_BITS'(1));

	always_comb begin
		state_d   = state_q;
		slot_d    = slot_q;
		count_d   = count_q;
		emit      = 1'b0;
		em_status = STAT_OK;
		em_slot   = '0;
		em_sig    = '0;
		map_we    = 1'b0;
		map_waddr = id_q;
		map_wdata = '0;
		map_re    = 1'b0;
		map_raddr = entity_id;
		sid_we    = 1'b0;
		sid_waddr = slot_q;
		sid_wdata = sid_rdata;
		sid_re    = 1'b0;
		sid_raddr = last_slot;
		sig_we    = 1'b0;
		sig_waddr = slot_q;
		sig_wdata = sig_rdata;
		sig_re    = 1'b0;
		sig_raddr = last_slot;

		case (state_q)
			ST_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					map_re  = 1'b1;
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				case (kind_q)
					KIND_ADD: begin
						if (out_free) begin
							emit    = 1'b1;
							state_d = ST_IDLE;
							if (present) begin
								em_status = STAT_PRESENT;
								em_slot   = map_slot;
							end else if (full) begin
								em_status = STAT_FULL;
							end else begin
								em_slot   = count_q[SLOT_BITS-1:0];
								sid_we    = 1'b1;
								sid_waddr = count_q[SLOT_BITS-1:0];
								sid_wdata = id_q;
								sig_we    = 1'b1;
								sig_waddr = count_q[SLOT_BITS-1:0];
								sig_wdata = '0;
								map_we    = 1'b1;
								map_wdata = {1'b1, count_q[SLOT_BITS-1:0]};
								count_d   = count_q + CNT_BITS'(1);
							end
						end
					end
					KIND_FIND: begin
						if (out_free) begin
							emit      = 1'b1;
							state_d   = ST_IDLE;
							em_status = present ? STAT_OK : STAT_NOT_FOUND;
							em_slot   = present ? map_slot : '0;
						end
					end
					KIND_REMOVE: begin
						if (present) begin
							// Fetch the id and signature of the last slot first.
							sid_re  = 1'b1;
							sig_re  = 1'b1;
							slot_d  = map_slot;
							state_d = ST_REMOVE;
						end else if (out_free) begin
							emit      = 1'b1;
							em_status = STAT_NOT_FOUND;
							state_d   = ST_IDLE;
						end
					end
					KIND_READ: begin
						if (present) begin
							sig_re    = 1'b1;
							sig_raddr = map_slot;
							slot_d    = map_slot;
							state_d   = ST_READ;
						end else if (out_free) begin
							emit      = 1'b1;
							em_status = STAT_NOT_FOUND;
							state_d   = ST_IDLE;
						end
					end
					KIND_WRITE: begin
						if (out_free) begin
							emit    = 1'b1;
							state_d = ST_IDLE;
							if (present) begin
								em_slot   = map_slot;
								sig_we    = 1'b1;
								sig_waddr = map_slot;
								sig_wdata = sig_q;
							end else begin
								em_status = STAT_NOT_FOUND;
							end
						end
					end
					default: begin
						if (out_free) begin
							emit    = 1'b1;
							state_d = ST_IDLE;
						end
					end
				endcase
			end
			ST_READ: begin
				if (out_free) begin
					emit    = 1'b1;
					em_slot = slot_q;
					em_sig  = sig_rdata;
					state_d = ST_IDLE;
				end
			end
			ST_REMOVE: begin
				// Move the last entry into the hole and repoint its map entry.
				sid_we    = 1'b1;
				sig_we    = 1'b1;
				map_we    = 1'b1;
				map_waddr = sid_rdata;
				map_wdata = {1'b1, slot_q};
				count_d   = count_q - CNT_BITS'(1);
				state_d   = ST_REMOVE2;
			end
			ST_REMOVE2: begin
				// Invalidating after the repoint leaves the entry invalid when
				// the removed id was the one in the last slot.
				if (out_free) begin
					map_we    = 1'b1;
					map_waddr = id_q;
					map_wdata = '0;
					emit      = 1'b1;
					em_slot   = slot_q;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ID_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			id_q   <= entity_id;
			sig_q  <= new_signature;
		end
		slot_q <= slot_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q    <= em_status;
			slot_out_q  <= em_slot;
			sig_out_q   <= em_sig;
			count_out_q <= count_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot          = slot_out_q;
	assign signature_out = sig_out_q;
	assign live_count    = count_out_q;

endmodule

### src/pitsr_checker.sv
// ----------------------------------------------------------------------------
// pitsr_props: port-level checks of the packed id table
// Watches the top level's ports and flags results that cannot be right.
// ----------------------------------------------------------------------------
module pitsr_props
	import pitsr_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [2:0]           kind,
	input logic [ID_BITS-1:0]   entity_id,
	input logic [SIG_BITS-1:0]  new_signature,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [1:0]           status,
	input logic [SLOT_BITS-1:0] slot,
	input logic [SIG_BITS-1:0]  signature_out,
	input logic [CNT_BITS-1:0]  live_count
);

	// A stalled result transaction stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot)
			&& $stable(signature_out) && $stable(live_count))
		else $error("stalled result changed");

	// A refusal for a full table only happens at capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> live_count == CNT_BITS'(MAX_ENTRIES))
		else $error("table full reported below capacity");

	// An absent id reports no slot and no signature.
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_NOT_FOUND |-> slot == '0 && signature_out == '0)
		else $error("not-found result carries data");

	// The live count never exceeds the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> live_count <= CNT_BITS'(MAX_ENTRIES))
		else $error("live count out of range");

	// An id already present always sits in a live slot.
	a_present_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_PRESENT |-> CNT_BITS'(slot) < live_count)
		else $error("present id points past the live entries");

endmodule

bind packed_id_table_swap_remove_top pitsr_props u_pitsr_props (.*);

### verif/pitsr_checker.sv
// ----------------------------------------------------------------------------
// pitsr_checker: result checker for the packed id table
// Watches both channels of the block. Every accepted transaction on the input
// runs through a local copy of the id map, the dense slot table and the live
// count. The result that it should produce is queued, and each result taken
// from the output is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module pitsr_checker
	import pitsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [2:0]           kind,
	input  logic [ID_BITS-1:0]   entity_id,
	input  logic [SIG_BITS-1:0]  new_signature,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [1:0]           status,
	input  logic [SLOT_BITS-1:0] slot,
	input  logic [SIG_BITS-1:0]  signature_out,
	input  logic [CNT_BITS-1:0]  live_count,
	output int                   failures,
	output int                   pending
);

	typedef struct packed {
		status_t              status;
		logic [SLOT_BITS-1:0] slot;
		logic [SIG_BITS-1:0]  signature;
		logic [CNT_BITS-1:0]  count;
	} table_result_t;

	logic                 id_live [ID_SPACE];
	logic [SLOT_BITS-1:0] id_slot [ID_SPACE];
	logic [ID_BITS-1:0]   slot_owner [MAX_ENTRIES];
	logic [SIG_BITS-1:0]  slot_sig [MAX_ENTRIES];
	logic [CNT_BITS-1:0]  live_total;

	table_result_t awaited_results[$];

	// Applies one operation to the local table and returns the result it gives.
	function automatic table_result_t apply_table_op(input logic [2:0] op,
			input logic [ID_BITS-1:0] id, input logic [SIG_BITS-1:0] sig);
		table_result_t        res;
		logic                 present;
		logic [SLOT_BITS-1:0] at;
		logic [SLOT_BITS-1:0] last;
		logic [ID_BITS-1:0]   moved_id;
		res = '{status: STAT_OK, slot: '0, signature: '0, count: '0};
		present = id_live[id];
		at = present ? id_slot[id] : '0;
		case (op)
			KIND_ADD: begin
				if (present) begin
					res.status = STAT_PRESENT;
					res.slot = at;
				end else if (live_total == MAX_ENTRIES) begin
					res.status = STAT_FULL;
				end else begin
					slot_owner[live_total[SLOT_BITS-1:0]] = id;
					slot_sig[live_total[SLOT_BITS-1:0]] = '0;
					id_slot[id] = live_total[SLOT_BITS-1:0];
					id_live[id] = 1'b1;
					res.slot = live_total[SLOT_BITS-1:0];
					live_total = live_total + 1'b1;
				end
			end
			KIND_FIND: begin
				res.status = present ? STAT_OK : STAT_NOT_FOUND;
				res.slot = at;
			end
			KIND_REMOVE: begin
				if (present) begin
					// The last live slot fills the hole; when the removed id is that
					// slot's own, the second map write below leaves it invalid.
					last = SLOT_BITS'(live_total - 1'b1);
					moved_id = slot_owner[last];
					slot_owner[at] = moved_id;
					slot_sig[at] = slot_sig[last];
					id_slot[moved_id] = at;
					id_live[moved_id] = 1'b1;
					id_live[id] = 1'b0;
					live_total = live_total - 1'b1;
					res.slot = at;
				end else begin
					res.status = STAT_NOT_FOUND;
				end
			end
			KIND_READ: begin
				if (present) begin
					res.slot = at;
					res.signature = slot_sig[at];
				end else begin
					res.status = STAT_NOT_FOUND;
				end
			end
			KIND_WRITE: begin
				if (present) begin
					slot_sig[at] = sig;
					res.slot = at;
				end else begin
					res.status = STAT_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		res.count = live_total;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			foreach (id_live[i]) id_live[i] = 1'b0;
			live_total = '0;
			awaited_results.delete();
			failures = 0;
			pending = 0;
		end else begin
			// A result never belongs to the transaction accepted at the same edge,
			// so the comparison goes first.
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result with no transaction waiting: status %0d slot %0d", status,
						slot);
					failures++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						failures++;
					end
					if (slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, slot);
						failures++;
					end
					if (signature_out !== want.signature) begin
						$error("signature_out: expected %h, got %h", want.signature,
							signature_out);
						failures++;
					end
					if (live_count !== want.count) begin
						$error("live_count: expected %0d, got %0d", want.count, live_count);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(apply_table_op(kind, entity_id, new_signature));
			pending = awaited_results.size();
		end
	end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the packed id table
// Drives a directed sequence of adds, finds, removes, reads and writes, then
// random phases that grow the table, fill it to capacity and shrink it again,
// with bursty input, a receiver that stalls on its own pattern and long
// output hold-offs. The checker beside the block reports the failures.
// ----------------------------------------------------------------------------
module tb;
	import pitsr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 150;
	localparam int ID_PICK_PCT = 90;
	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [2:0]           kind = KIND_FIND;
	logic [ID_BITS-1:0]   entity_id = '0;
	logic [SIG_BITS-1:0]  new_signature = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           status;
	logic [SLOT_BITS-1:0] slot;
	logic [SIG_BITS-1:0]  signature_out;
	logic [CNT_BITS-1:0]  live_count;
	int                   failures;
	int                   pending;

	// Stimulus side bookkeeping: which ids are live, for picking well-formed ids.
	logic               id_in_use [ID_SPACE];
	logic [ID_BITS-1:0] roster[$];
	int                 burst_left = 0;
	logic               calm = 1'b0;
	int                 hold_asks = 0;

	int hold_seen = 0;
	int hold_left = 0;
	int window_left = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	packed_id_table_swap_remove_top dut (.*);
	pitsr_checker table_watch (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: stall rate is picked anew every window, long hold-offs on request.
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (window_left == 0) begin
			window_left = $urandom_range(8, 64);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 80;
			endcase
		end
		window_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic send_op(input logic [2:0] op, input logic [ID_BITS-1:0] id,
			input logic [SIG_BITS-1:0] sig);
		int gap;
		int idx;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (calm)
				gap = 0;
			else if ($urandom_range(0, 99) < 70)
				gap = $urandom_range(0, 3);
			else
				gap = $urandom_range(4, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		kind <= op;
		entity_id <= id;
		new_signature <= sig;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (op == KIND_ADD && !id_in_use[id] && roster.size() < MAX_ENTRIES) begin
			id_in_use[id] = 1'b1;
			roster.push_back(id);
		end else if (op == KIND_REMOVE && id_in_use[id]) begin
			id_in_use[id] = 1'b0;
			idx = 0;
			while (roster[idx] != id) idx++;
			roster.delete(idx);
		end
	endtask

	// Mostly well-formed: adds of absent ids, other operations on live ids.
	task automatic random_op(input int add_pct, input int remove_pct);
		int                 pick;
		int                 start;
		logic [2:0]         op;
		logic [ID_BITS-1:0] id;
		pick = $urandom_range(0, 99);
		if (pick < add_pct) begin
			op = KIND_ADD;
		end else if (pick < add_pct + remove_pct) begin
			op = KIND_REMOVE;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				op = KIND_UNUSED_FIRST + 3'($urandom_range(0, 2));
			else if (pick < 36)
				op = KIND_FIND;
			else if (pick < 68)
				op = KIND_READ;
			else
				op = KIND_WRITE;
		end
		id = ID_BITS'($urandom());
		if ($urandom_range(0, 99) < ID_PICK_PCT) begin
			if (op == KIND_ADD && roster.size() < MAX_ENTRIES) begin
				start = $urandom_range(0, ID_SPACE - 1);
				for (int n = 0; n < ID_SPACE; n++) begin
					if (!id_in_use[(start + n) % ID_SPACE]) begin
						id = ID_BITS'((start + n) % ID_SPACE);
						break;
					end
				end
			end else if (op != KIND_ADD && roster.size() > 0) begin
				id = roster[$urandom_range(0, roster.size() - 1)];
			end
		end
		send_op(op, id, $urandom());
	endtask

	initial begin
		foreach (id_in_use[i]) id_in_use[i] = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Operations on an empty table all miss; then adds, writes, reads and a find.
		send_op(KIND_FIND, 10'd0, '0);
		send_op(KIND_REMOVE, 10'd5, '1);
		send_op(KIND_READ, 10'd7, '0);
		send_op(KIND_WRITE, 10'd9, 32'hFFFF_FFFF);
		send_op(KIND_ADD, 10'd0, '1);
		send_op(KIND_ADD, 10'd1023, '0);
		send_op(KIND_ADD, 10'd0, '0);
		send_op(KIND_ADD, 10'd512, 32'h1234_5678);
		send_op(KIND_WRITE, 10'd1023, 32'hFFFF_FFFF);
		send_op(KIND_WRITE, 10'd0, 32'h5A5A_A5A5);
		send_op(KIND_READ, 10'd0, '0);
		send_op(KIND_READ, 10'd1023, '0);
		send_op(KIND_READ, 10'd512, '1);
		send_op(KIND_FIND, 10'd1023, '0);
		// Slot zero is vacated and refilled from the last slot.
		send_op(KIND_REMOVE, 10'd0, '0);
		send_op(KIND_READ, 10'd512, '0);
		send_op(KIND_FIND, 10'd512, '0);
		// The removed id now occupies the last slot itself.
		send_op(KIND_REMOVE, 10'd1023, '0);
		send_op(KIND_FIND, 10'd1023, '0);
		send_op(KIND_UNUSED_FIRST, 10'd512, '1);
		send_op(KIND_UNUSED_FIRST + 3'd1, 10'd512, '0);
		send_op(KIND_UNUSED_FIRST + 3'd2, 10'd1023, '1);
		send_op(KIND_REMOVE, 10'd512, '0);
		send_op(KIND_READ, 10'd512, '0);

		repeat (100) random_op(40, 25);
		calm <= 1'b1;
		repeat (60) random_op(35, 30);
		calm <= 1'b0;
		while (roster.size() < 300) random_op(95, 2);
		hold_asks <= hold_asks + 1;
		while (roster.size() < MAX_ENTRIES) random_op(95, 2);
		// With every id live, adds are refused and the other kinds still work.
		repeat (40) random_op(30, 0);
		hold_asks <= hold_asks + 1;
		repeat (80) random_op(10, 60);
		in_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### filelist.f
src/pitsr_pkg.sv
src/pitsr_ram.sv
src/packed_id_table_swap_remove_top.sv
src/pitsr_checker.sv
verif/pitsr_checker.sv
verif/tb.sv
